FILE: rtl/ptrx_pkg.sv
`timescale 1ns / 1ps
// Shared types, character codes and helper functions of the motif-to-regex translator.
// No dependencies; the top level, front end, queue, back end and testbench import this package.
package ptrx_pkg;

  // Queue between front and back end
  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  // Character codes
  localparam logic [7:0] ChDash   = 8'h2D;  // '-'
  localparam logic [7:0] ChDot    = 8'h2E;  // '.'
  localparam logic [7:0] ChComma  = 8'h2C;  // ','
  localparam logic [7:0] ChGt     = 8'h3E;  // '>'
  localparam logic [7:0] ChLt     = 8'h3C;  // '<'
  localparam logic [7:0] ChLParen = 8'h28;  // '('
  localparam logic [7:0] ChRParen = 8'h29;  // ')'
  localparam logic [7:0] ChLBrace = 8'h7B;  // '{'
  localparam logic [7:0] ChRBrace = 8'h7D;  // '}'
  localparam logic [7:0] ChLBrack = 8'h5B;  // '['
  localparam logic [7:0] ChRBrack = 8'h5D;  // ']'
  localparam logic [7:0] ChCaret  = 8'h5E;  // '^'
  localparam logic [7:0] ChDollar = 8'h24;  // '$'
  localparam logic [7:0] ChLowX   = 8'h78;  // 'x'
  localparam logic [7:0] ChUpX    = 8'h58;  // 'X'
  localparam logic [7:0] ChNone   = 8'h00;

  localparam logic [7:0] CountMax = 8'hFF;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_CHAR  = 2'd1,
    ST_NO_PERIOD = 2'd2
  } status_e;

  // One classified input: up to three regex characters, then an optional status result
  typedef struct packed {
    logic [2:0][7:0] chars;
    logic [1:0]      nchars;
    logic            done;
    status_e         status;
    logic [7:0]      count;
  } cmd_t;

  function automatic logic is_lower(logic [7:0] c);
    return (c >= 8'h61) && (c <= 8'h7A);
  endfunction

  function automatic logic is_upper(logic [7:0] c);
    return (c >= 8'h41) && (c <= 8'h5A);
  endfunction

  function automatic logic [7:0] to_upper(logic [7:0] c);
    return is_lower(c) ? (c - 8'd32) : c;
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_allowed(logic [7:0] up);
    logic punct;
    punct = (up == ChDash)   || (up == ChDot)    || (up == ChComma)  ||
            (up == ChLBrack) || (up == ChRBrack) || (up == ChLParen) ||
            (up == ChRParen) || (up == ChLBrace) || (up == ChRBrace) ||
            (up == ChLt)     || (up == ChGt);
    return is_upper(up) || is_digit(up) || punct;
  endfunction

endpackage

FILE: rtl/ptrx_in_if.sv
`timescale 1ns / 1ps
// Input channel of the translator: one pattern character per transfer.
// No dependencies.
interface ptrx_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] pattern_char;
  logic       final_char;

  modport source (output valid, output pattern_char, output final_char, input ready);
  modport sink   (input valid, input pattern_char, input final_char, output ready);
endinterface

FILE: rtl/ptrx_out_if.sv
`timescale 1ns / 1ps
// Output channel of the translator: one regex character or status result per transfer.
// No dependencies.
interface ptrx_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       has_char;
  logic       item_end;
  logic       pattern_done;
  logic [1:0] status;
  logic [7:0] group_count;

  modport source (output valid, output out_char, output has_char, output item_end,
                  output pattern_done, output status, output group_count, input ready);
  modport sink   (input valid, input out_char, input has_char, input item_end,
                  input pattern_done, input status, input group_count, output ready);
endinterface

FILE: rtl/prosite_to_regex_translator_unit.sv
`timescale 1ns / 1ps
// Top level of the motif-to-regex translator: front end, command queue, back end.
// Depends on ptrx_pkg, ptrx_in_if, ptrx_out_if, ptrx_front, ptrx_queue, ptrx_back.

// The block takes one pattern character per transfer and streams out its regex
// translation, one character per transfer, followed by a status result after the
// character marked final. The front end classifies a character in the cycle it is
// taken and can take one every cycle while the two-entry command queue has room;
// the back end moves one result per cycle into the output register while the
// consumer is ready; a character yields zero to three results, four for a final one
// that expands to three characters. Sustained rate is set by the back end at one
// result per cycle. Results are emitted before the status is known; on a nonzero
// status the consumer drops everything of that pattern.
module prosite_to_regex_translator_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  ptrx_in_if.sink    in_i,
  ptrx_out_if.source out_o
);
  import ptrx_pkg::*;

  logic push, full, empty, pop;
  cmd_t cmd, head;

  ptrx_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .full_i (full),
    .push_o (push),
    .cmd_o  (cmd)
  );

  ptrx_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (cmd),
    .full_o  (full),
    .empty_o (empty),
    .pop_i   (pop),
    .head_o  (head)
  );

  ptrx_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .empty_i (empty),
    .head_i  (head),
    .pop_o   (pop),
    .out_o   (out_o)
  );

endmodule

FILE: rtl/ptrx_front.sv
`timescale 1ns / 1ps
// Front end: accepts pattern characters, tracks group and error state, builds commands.
// Depends on ptrx_pkg and ptrx_in_if.
module ptrx_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  ptrx_in_if.sink        in_i,
  input  logic           full_i,
  output logic           push_o,
  output ptrx_pkg::cmd_t cmd_o
);
  import ptrx_pkg::*;

  logic       open_q, open_d;
  logic [7:0] cnt_q, cnt_d;
  logic       bad_q, bad_d;
  logic       accept;

  logic [7:0] c, up, t0, t1;
  logic [1:0] tn;
  logic       opens;

  assign in_i.ready = !full_i;
  assign accept     = in_i.valid && in_i.ready;
  assign c          = in_i.pattern_char;
  assign up         = to_upper(c);

  // Plain translation of characters that are neither separators nor anchors
  always_comb begin
    t0 = up;
    t1 = ChNone;
    tn = 2'd1;
    unique case (c)
      ChLParen: t0 = ChLBrace;
      ChRParen: t0 = ChRBrace;
      ChLBrace: begin
        t0 = ChLBrack;
        t1 = ChCaret;
        tn = 2'd2;
      end
      ChRBrace: t0 = ChRBrack;
      ChLowX, ChUpX: t0 = ChDot;
      default: t0 = up;
    endcase
  end

  assign opens = !open_q && (((is_lower(c) || is_upper(c)) && (up != ChUpX)) ||
                             (c == ChLBrack) || (c == ChLBrace));

  always_comb begin
    cmd_o.chars  = '0;
    cmd_o.nchars = 2'd0;
    open_d       = open_q;
    cnt_d        = cnt_q;
    bad_d        = bad_q | !is_allowed(up);
    if ((c == ChDash) || (c == ChDot)) begin
      if (open_q) begin
        cmd_o.chars[0] = ChRParen;
        cmd_o.nchars   = 2'd1;
      end
      open_d = 1'b0;
    end else if (c == ChGt) begin
      if (open_q) begin
        cmd_o.chars[0] = ChRParen;
        cmd_o.chars[1] = ChDollar;
        cmd_o.nchars   = 2'd2;
      end else begin
        cmd_o.chars[0] = ChDollar;
        cmd_o.nchars   = 2'd1;
      end
      open_d = 1'b0;
    end else if (c == ChLt) begin
      cmd_o.chars[0] = ChCaret;
      cmd_o.nchars   = 2'd1;
    end else if (opens) begin
      cmd_o.chars[0] = ChLParen;
      cmd_o.chars[1] = t0;
      cmd_o.chars[2] = t1;
      cmd_o.nchars   = tn + 2'd1;
      open_d         = 1'b1;
      if (cnt_q != CountMax) begin
        cnt_d = cnt_q + 8'd1;
      end
    end else begin
      cmd_o.chars[0] = t0;
      cmd_o.chars[1] = t1;
      cmd_o.nchars   = tn;
    end
    cmd_o.done  = in_i.final_char;
    cmd_o.count = cnt_d;
    if (bad_d) begin
      cmd_o.status = ST_BAD_CHAR;
    end else if (c != ChDot) begin
      cmd_o.status = ST_NO_PERIOD;
    end else begin
      cmd_o.status = ST_OK;
    end
  end

  // Drop inputs that produce no result
  assign push_o = accept && ((cmd_o.nchars != 2'd0) || in_i.final_char);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q <= 1'b0;
      cnt_q  <= 8'd0;
      bad_q  <= 1'b0;
    end else if (accept) begin
      if (in_i.final_char) begin
        open_q <= 1'b0;
        cnt_q  <= 8'd0;
        bad_q  <= 1'b0;
      end else begin
        open_q <= open_d;
        cnt_q  <= cnt_d;
        bad_q  <= bad_d;
      end
    end
  end

  a_final_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && in_i.final_char |=> !open_q && (cnt_q == 8'd0) && !bad_q)
    else $error("pattern state not cleared after last character");

  a_open_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o && opens |-> (cmd_o.count != 8'd0) && (cmd_o.chars[0] == ChLParen))
    else $error("group opened without count");

endmodule

FILE: rtl/ptrx_queue.sv
`timescale 1ns / 1ps
// Short command queue between front and back end.
// Depends on ptrx_pkg.
module ptrx_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  ptrx_pkg::cmd_t cmd_i,
  output logic           full_o,
  output logic           empty_o,
  input  logic           pop_i,
  output ptrx_pkg::cmd_t head_o
);
  import ptrx_pkg::*;

  cmd_t             mem_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0] cnt_q;

  assign full_o  = (cnt_q == QCntW'(QDepth));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_ptr_q];

  function automatic logic [QPtrW-1:0] next_ptr(logic [QPtrW-1:0] p);
    return (p == QPtrW'(QDepth - 1)) ? '0 : p + QPtrW'(1);
  endfunction

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= next_ptr(wr_ptr_q);
      end
      if (pop_i) begin
        rd_ptr_q <= next_ptr(rd_ptr_q);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + QCntW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - QCntW'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o) && !(pop_i && empty_o))
    else $error("queue overflow or underflow");

endmodule

FILE: rtl/ptrx_back.sv
`timescale 1ns / 1ps
// Back end: walks the queue head one result per cycle into the output register while it is free or being taken.
// Depends on ptrx_pkg and ptrx_out_if.
module ptrx_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           empty_i,
  input  ptrx_pkg::cmd_t head_i,
  output logic           pop_o,
  ptrx_out_if.source     out_o
);
  import ptrx_pkg::*;

  logic [1:0] pos_q;
  logic [2:0] total;
  logic       is_last, load;
  logic       has;
  logic [7:0] ch;

  logic       valid_q;
  logic [7:0] char_q, count_q;
  logic       has_q, end_q, done_q;
  status_e    status_q;

  assign total   = {1'b0, head_i.nchars} + {2'b0, head_i.done};
  assign is_last = ({1'b0, pos_q} + 3'd1) == total;
  assign load    = !empty_i && (!valid_q || out_o.ready);
  assign pop_o   = load && is_last;
  assign has     = pos_q < head_i.nchars;

  always_comb begin
    unique case (pos_q)
      2'd0:    ch = head_i.chars[0];
      2'd1:    ch = head_i.chars[1];
      2'd2:    ch = head_i.chars[2];
      default: ch = ChNone;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      pos_q   <= 2'd0;
    end else begin
      if (load) begin
        valid_q <= 1'b1;
        pos_q   <= is_last ? 2'd0 : pos_q + 2'd1;
      end else if (out_o.ready) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      char_q   <= has ? ch : ChNone;
      has_q    <= has;
      end_q    <= is_last;
      done_q   <= !has;
      status_q <= has ? ST_OK : head_i.status;
      count_q  <= head_i.count;
    end
  end

  assign out_o.valid        = valid_q;
  assign out_o.out_char     = char_q;
  assign out_o.has_char     = has_q;
  assign out_o.item_end     = end_q;
  assign out_o.pattern_done = done_q;
  assign out_o.status       = status_q;
  assign out_o.group_count  = count_q;

  a_done_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && done_q |-> end_q && !has_q && (char_q == ChNone))
    else $error("status result not last of its item");

endmodule

FILE: bench/prosite_to_regex_translator_unit_test.sv
`timescale 1ns / 1ps
// Testbench of the motif-to-regex translator: directed and random motifs, checked against a
// behavioral translation model in this file. Depends on the top, ptrx_pkg, both interfaces.
module prosite_to_regex_translator_unit_test;
  import ptrx_pkg::*;

  localparam int          IdlePct     = 15;
  localparam int          DrainCycles = 8;
  localparam int          HoldCycles  = 150;
  localparam int          StallLimit  = 2000;
  localparam int          RandomItems = 16;
  localparam logic [7:0]  LowA        = 8'h61;  // 'a'
  localparam logic [7:0]  LowZ        = 8'h7A;  // 'z'
  localparam logic [7:0]  UpA         = 8'h41;  // 'A'
  localparam logic [7:0]  UpZ         = 8'h5A;  // 'Z'
  localparam logic [7:0]  Digit0      = 8'h30;  // '0'
  localparam logic [7:0]  CaseShift   = 8'd32;

  typedef logic [7:0] motif_t[$];

  typedef struct packed {
    logic [7:0] ch;
    logic       has_char;
    logic       item_end;
    logic       pattern_done;
    status_e    status;
    logic [7:0] group_count;
  } regex_out_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  ptrx_in_if  in_if ();
  ptrx_out_if out_if ();

  prosite_to_regex_translator_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always #2 clk_i = ~clk_i;

  // Translation state tracked alongside the block
  logic       grp_open;
  logic [7:0] grp_cnt;
  logic       bad_seen;
  regex_out_t expected_regex[$];

  int  mismatches  = 0;
  int  chars_sent  = 0;
  bit  quiet       = 1'b0;
  bit  rx_hold_req = 1'b0;
  int  idle_cycles = 0;

  function automatic logic in_motif_alphabet(input logic [7:0] up);
    string alphabet;
    alphabet = "-ABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789[],(){}<>.";
    for (int k = 0; k < alphabet.len(); k++) begin
      if (alphabet[k] == up) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void predict_translation(input logic [7:0] c, input logic fin);
    logic [7:0] up;
    logic [7:0] emit[$];
    regex_out_t res[$];
    regex_out_t r;
    status_e    st;
    up = (c >= LowA && c <= LowZ) ? c - CaseShift : c;
    if (!in_motif_alphabet(up)) bad_seen = 1'b1;
    if (c == ChDash || c == ChDot || c == ChGt) begin
      if (grp_open) begin
        emit = {emit, ChRParen};
        grp_open = 1'b0;
      end
      if (c == ChGt) emit = {emit, ChDollar};
    end else if (c == ChLt) begin
      emit = {emit, ChCaret};
    end else begin
      if (!grp_open && (((up >= UpA && up <= UpZ) && up != ChUpX) ||
                        c == ChLBrack || c == ChLBrace)) begin
        emit = {emit, ChLParen};
        if (grp_cnt != CountMax) grp_cnt++;
        grp_open = 1'b1;
      end
      case (c)
        ChLParen:      emit = {emit, ChLBrace};
        ChRParen:      emit = {emit, ChRBrace};
        ChLBrace: begin
          emit = {emit, ChLBrack};
          emit = {emit, ChCaret};
        end
        ChRBrace:      emit = {emit, ChRBrack};
        ChLowX, ChUpX: emit = {emit, ChDot};
        default:       emit = {emit, up};
      endcase
    end
    foreach (emit[k]) begin
      r = '{ch: emit[k], has_char: 1'b1, item_end: 1'b0, pattern_done: 1'b0,
            status: ST_OK, group_count: grp_cnt};
      res = {res, r};
    end
    if (fin) begin
      if (bad_seen)        st = ST_BAD_CHAR;
      else if (c != ChDot) st = ST_NO_PERIOD;
      else                 st = ST_OK;
      r = '{ch: ChNone, has_char: 1'b0, item_end: 1'b0, pattern_done: 1'b1,
            status: st, group_count: grp_cnt};
      res = {res, r};
      grp_open = 1'b0;
      grp_cnt  = 8'd0;
      bad_seen = 1'b0;
    end
    foreach (res[k]) begin
      r = res[k];
      r.item_end = (k == res.size() - 1);
      expected_regex = {expected_regex, r};
    end
  endfunction

  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t: %s", $realtime, what);
    mismatches++;
  endtask

  // Compare each result at the falling edge before the rising edge that transfers it
  always @(negedge clk_i) begin : check_results
    regex_out_t want;
    if (rst_ni === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      if (expected_regex.size() == 0) begin
        report_mismatch($sformatf("unexpected result char=%h done=%b",
                                  out_if.out_char, out_if.pattern_done));
      end else begin
        want = expected_regex.pop_front();
        if (out_if.out_char !== want.ch || out_if.has_char !== want.has_char ||
            out_if.item_end !== want.item_end || out_if.pattern_done !== want.pattern_done ||
            out_if.status !== want.status || out_if.group_count !== want.group_count) begin
          report_mismatch($sformatf(
            "got char=%h has=%b end=%b done=%b st=%0d cnt=%0d, want %h %b %b %b %0d %0d",
            out_if.out_char, out_if.has_char, out_if.item_end, out_if.pattern_done,
            out_if.status, out_if.group_count, want.ch, want.has_char, want.item_end,
            want.pattern_done, want.status, want.group_count));
        end
      end
    end
  end

  // End the run when no transfer happens for too long
  always @(negedge clk_i) begin
    if (rst_ni === 1'b1) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= StallLimit) begin
          $display("Verification failed");
          $finish;
        end
      end
    end
  end

  // Result receiver: random stalls, or a long hold-off when requested
  initial begin : receiver
    int hold_left;
    hold_left    = 0;
    out_if.ready = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        hold_left   = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= quiet || ($urandom_range(99) >= IdlePct);
      end
    end
  end

  // Entered and left at a rising edge; valid stays high when the next char follows at once
  task automatic send_char(input logic [7:0] c, input logic fin);
    while (!quiet && $urandom_range(99) < IdlePct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid        <= 1'b1;
    in_if.pattern_char <= c;
    in_if.final_char   <= fin;
    @(negedge clk_i);
    while (in_if.ready !== 1'b1) @(negedge clk_i);
    predict_translation(c, fin);
    chars_sent++;
    @(posedge clk_i);
  endtask

  task automatic send_bytes(input motif_t seq, input bit closes);
    for (int i = 0; i < seq.size(); i++) begin
      send_char(seq[i], closes && (i == seq.size() - 1));
    end
  endtask

  task automatic send_text(input string s, input bit closes);
    motif_t seq;
    for (int i = 0; i < s.len(); i++) seq = {seq, s[i]};
    send_bytes(seq, closes);
  endtask

  task automatic wait_drain();
    in_if.valid <= 1'b0;
    while (expected_regex.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  function automatic logic [7:0] any_letter();
    return 8'($urandom_range(25)) + ($urandom_range(1) ? UpA : LowA);
  endfunction

  function automatic motif_t make_motif();
    motif_t q;
    int     n;
    n = $urandom_range(1, 6);
    if ($urandom_range(3) == 0) q = {q, ChLt};
    for (int i = 0; i < n; i++) begin
      if (i > 0) q = {q, ChDash};
      case ($urandom_range(4))
        0: q = {q, any_letter()};
        1: q = {q, ($urandom_range(1) ? ChUpX : ChLowX)};
        2: begin
          q = {q, ChLBrack};
          repeat ($urandom_range(1, 3)) q = {q, any_letter()};
          q = {q, ChRBrack};
        end
        3: begin
          q = {q, ChLBrace};
          repeat ($urandom_range(1, 2)) q = {q, any_letter()};
          q = {q, ChRBrace};
        end
        default: begin
          q = {q, ($urandom_range(1) ? any_letter() : ChUpX)};
          q = {q, ChLParen};
          q = {q, 8'(Digit0 + 8'($urandom_range(9)))};
          if ($urandom_range(1)) begin
            q = {q, ChComma};
            q = {q, 8'(Digit0 + 8'($urandom_range(9)))};
          end
          q = {q, ChRParen};
        end
      endcase
    end
    if ($urandom_range(3) == 0) q = {q, ChGt};
    q = {q, ChDot};
    // corrupt some motifs: stray byte, or no closing period
    if ($urandom_range(99) < 20) q[$urandom_range(q.size() - 1)] = 8'($urandom_range(255));
    if ($urandom_range(99) < 10 && q.size() > 1) void'(q.pop_back());
    return q;
  endfunction

  task automatic test_translation_rules();
    send_text("--<C-x(2,4)-[ST]-{PG}-a(3)-X.", 1'b1);
    send_text("[ag]-x>", 1'b1);
    send_text("{", 1'b1);
    send_text(".", 1'b1);
    send_text("A-", 1'b1);
    wait_drain();
  endtask

  task automatic test_disallowed_chars();
    motif_t seq;
    seq = '{UpA, 8'hFF, 8'h00, 8'h80, ChDot};
    send_bytes(seq, 1'b1);
    // both errors: the disallowed char wins over the missing period
    seq = '{8'h2A, UpA, 8'h7F, 8'h20};
    send_bytes(seq, 1'b1);
    wait_drain();
  endtask

  task automatic test_group_count();
    quiet = 1'b1;
    repeat (3) send_text("A-", 1'b0);
    send_text(".", 1'b1);
    wait_drain();
    quiet = 1'b0;
  endtask

  task automatic test_receiver_hold_off();
    @(negedge clk_i) rx_hold_req = 1'b1;
    @(posedge clk_i);
    send_text("<{P}-{PG}-[ST]-A-B-C-D-E-F-G>", 1'b1);
    wait_drain();
  endtask

  task automatic test_sender_pause();
    send_text("<R-G-[DE]", 1'b0);
    in_if.valid <= 1'b0;
    while (expected_regex.size() != 0) @(posedge clk_i);
    send_text("-x(2)-{W}.", 1'b1);
    wait_drain();
  endtask

  task automatic test_back_to_back();
    quiet = 1'b1;
    send_text("{C}-[LIVM]-x(3)-G-K-{KR}-x>", 1'b1);
    send_text("<wyh-x.", 1'b1);
    wait_drain();
    quiet = 1'b0;
  endtask

  task automatic test_random_motifs();
    int stop_at;
    stop_at = chars_sent + RandomItems;
    while (chars_sent < stop_at) send_bytes(make_motif(), 1'b1);
    wait_drain();
  endtask

  initial begin : run_tests
    rst_ni             = 1'b0;
    in_if.valid        = 1'b0;
    in_if.pattern_char = 8'h00;
    in_if.final_char   = 1'b0;
    grp_open           = 1'b0;
    grp_cnt            = 8'd0;
    bad_seen           = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_translation_rules();
    test_disallowed_chars();
    test_group_count();
    test_receiver_hold_off();
    test_sender_pause();
    test_back_to_back();
    test_random_motifs();
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/ptrx_pkg.sv
rtl/ptrx_in_if.sv
rtl/ptrx_out_if.sv
rtl/ptrx_front.sv
rtl/ptrx_queue.sv
rtl/ptrx_back.sv
rtl/prosite_to_regex_translator_unit.sv
bench/prosite_to_regex_translator_unit_test.sv
